/* src/modular_exponentiation_unit_macros.svh */
// Assertion macros shared by the modular exponentiation unit.
`ifndef MODULAR_EXPONENTIATION_UNIT_MACROS_SVH
`define MODULAR_EXPONENTIATION_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define MEU_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

`define MEU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define MEU_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)

`define MEU_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* src/meu_pkg.sv */
`default_nettype none

package meu_pkg;

   localparam int BaseBits = 63;
   localparam int ExpBits  = 63;
   localparam int ModBits  = 32;
   localparam int ResBits  = 32;
   localparam int ProdBits = 2 * ModBits;
   // The remainder unit must take both a product and an unreduced base.
   localparam int DvdBits  = (ProdBits > BaseBits) ? ProdBits : BaseBits + 1;
   localparam int CntBits  = $clog2(DvdBits);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RED_BASE,
      ST_CHECK,
      ST_MUL_ACC,
      ST_RED_ACC,
      ST_MUL_SQ,
      ST_RED_SQ,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } red_status_type;

endpackage

`default_nettype wire

/* src/modular_exponentiation_unit.sv */
// A zero exponent or modulus needs no reduction; otherwise the base is reduced, then each
// exponent bit up to the highest set bit multiplies into the result if set and squares the
// base if below that bit. The bit-serial remainder unit reduces each modular product.
// Throughput: one item at a time; a new item is taken the cycle after the result strobe.
// Reset (synchronous, active high) returns the sequencer to idle and drops any item at work.
// The result strobe lasts one cycle and the receiver cannot stall it.
`default_nettype none

`include "modular_exponentiation_unit_macros.svh"

module modular_exponentiation_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [meu_pkg::BaseBits-1:0]    req_base_value,
   input  logic [meu_pkg::ExpBits-1:0]     req_exponent,
   input  logic [31:0]                     req_modulus,
   output logic                            rsp_valid,
   output logic [meu_pkg::ResBits-1:0]     rsp_residue
);
   import meu_pkg::*;

   state_type            state_ff, state_in;
   logic [ExpBits-1:0]   exp_ff, exp_in;
   logic [ModBits-1:0]   mod_ff, mod_in;
   logic [ModBits-1:0]   acc_ff, acc_in;
   logic [ModBits-1:0]   sq_ff, sq_in;

   logic [ModBits-1:0]   req_mod;
   logic [ModBits-1:0]   mul_a;
   logic [ProdBits-1:0]  product;
   logic                 red_go;
   logic [DvdBits-1:0]   red_dividend;
   red_status_type       red_status;
   logic [ModBits-1:0]   red_rem;

   assign req_mod = req_modulus[ModBits-1:0];

   // The single multiplier serves both the accumulate and the squaring step;
   // its product is registered in the remainder unit's dividend register.
   assign mul_a   = (state_ff == ST_MUL_ACC) ? acc_ff : sq_ff;
   assign product = ProdBits'(mul_a) * ProdBits'(sq_ff);

   meu_reduce u_reduce (
      .clock     (clock),
      .reset     (reset),
      .go        (red_go),
      .dividend  (red_dividend),
      .modulus   (mod_ff),
      .status    (red_status),
      .remainder (red_rem)
   );

   always_comb begin
      state_in     = state_ff;
      exp_in       = exp_ff;
      mod_in       = mod_ff;
      acc_in       = acc_ff;
      sq_in        = sq_ff;
      red_go       = 1'b0;
      red_dividend = DvdBits'(req_base_value);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               exp_in = req_exponent;
               mod_in = req_mod;
               priority if (req_mod == '0) begin
                  acc_in   = '0;
                  state_in = ST_DONE;
               end else if (req_exponent == '0) begin
                  acc_in   = ModBits'(1);
                  state_in = ST_DONE;
               end else begin
                  red_go   = 1'b1;
                  state_in = ST_RED_BASE;
               end
            end
         end
         ST_RED_BASE: begin
            if (red_status.done) begin
               sq_in    = red_rem;
               acc_in   = ModBits'(1);
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = exp_ff[0] ? ST_MUL_ACC : ST_MUL_SQ;
         end
         ST_MUL_ACC: begin
            red_go       = 1'b1;
            red_dividend = DvdBits'(product);
            state_in     = ST_RED_ACC;
         end
         ST_RED_ACC: begin
            if (red_status.done) begin
               acc_in = red_rem;
               // No squaring is needed once the last set bit has been used.
               state_in = (exp_ff[ExpBits-1:1] == '0) ? ST_DONE : ST_MUL_SQ;
            end
         end
         ST_MUL_SQ: begin
            red_go       = 1'b1;
            red_dividend = DvdBits'(product);
            state_in     = ST_RED_SQ;
         end
         ST_RED_SQ: begin
            if (red_status.done) begin
               sq_in    = red_rem;
               exp_in   = exp_ff >> 1;
               state_in = ST_CHECK;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      exp_ff <= exp_in;
      mod_ff <= mod_in;
      acc_ff <= acc_in;
      sq_ff  <= sq_in;
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_valid   = (state_ff == ST_DONE);
   assign rsp_residue = ResBits'(acc_ff);

   `MEU_ASSERT_NEXT(a_rsp_one_cycle, clock, reset, rsp_valid, !rsp_valid)
   `MEU_ASSERT_NEXT(a_accept_goes_busy, clock, reset, start && !busy, busy)
   `MEU_ASSERT_IMPLIES(a_done_in_wait, clock, reset, red_status.done,
      state_ff == ST_RED_BASE || state_ff == ST_RED_ACC || state_ff == ST_RED_SQ)
   `MEU_ASSERT_IMPLIES(a_go_when_free, clock, reset, red_go, !red_status.busy && !red_status.done)

endmodule

`default_nettype wire

/* src/meu_reduce.sv */
`default_nettype none

module meu_reduce (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             go,
   input  logic [meu_pkg::DvdBits-1:0]      dividend,
   input  logic [meu_pkg::ModBits-1:0]      modulus,
   output meu_pkg::red_status_type          status,
   output logic [meu_pkg::ModBits-1:0]      remainder
);
   import meu_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CntBits-1:0]  cnt_ff, cnt_in;
   logic [DvdBits-1:0]  dvd_ff, dvd_in;
   logic [ModBits-1:0]  rem_ff, rem_in;

   logic [ModBits:0]    trial;
   logic [ModBits+1:0]  diff;
   logic                last_step;

   // Restoring remainder: one dividend bit is brought down each cycle. The
   // partial remainder stays below the modulus, so the trial value is below
   // twice the modulus and a single subtraction suffices.
   assign trial     = {rem_ff, dvd_ff[DvdBits-1]};
   assign diff      = {1'b0, trial} - {2'b00, modulus};
   assign last_step = (cnt_ff == CntBits'(DvdBits - 1));

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      if (go) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DvdBits-2:0], 1'b0};
         rem_in = diff[ModBits+1] ? trial[ModBits-1:0] : diff[ModBits-1:0];
         cnt_in = cnt_ff + CntBits'(1);
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder   = rem_ff;

endmodule

`default_nettype wire
